/* hdl/bsiu_pkg.sv */
// Package for the bounded stack with indexed update.
// Holds the transfer payload types, action and status codes, state encoding
// and the command/status structs between controller and datapath. No dependencies.
package bsiu_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W = 32;
    localparam int POS_W = 5;

    typedef enum logic [1:0] {
        ACT_PUSH    = 2'd0,
        ACT_POP     = 2'd1,
        ACT_CHANGE  = 2'd2,
        ACT_DISPLAY = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_OVERFLOW  = 3'd1,
        STS_UNDERFLOW = 3'd2,
        STS_BAD_INDEX = 3'd3,
        STS_EMPTY     = 3'd4
    } status_t;

    typedef struct packed {
        action_t                    action;
        logic signed [WORD_W-1:0]   value;
        logic        [POS_W-1:0]    position;
    } in_item_t;

    typedef struct packed {
        status_t                    status;
        logic signed [WORD_W-1:0]   data;
        logic                       last;
    } out_item_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESP,
        S_READ,
        S_DRESP
    } state_t;

    typedef struct packed {
        logic accept;
        logic load_rd;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic disp_start;
        logic ptr_zero;
    } dp_sts_t;

endpackage

/* hdl/bsiu_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bsiu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/bsiu_ctrl.sv */
// Controller state machine of the bounded stack.
// Depends on bsiu_pkg for the state type and the command/status structs.
module bsiu_ctrl
    import bsiu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ctrl_cmd_t cmd,
    input  dp_sts_t   sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.disp_start ? S_READ : S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_DRESP;
            end
            S_DRESP:
            begin
                if (out_ready)
                begin
                    state_next = sts.ptr_zero ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.accept  = 1'b0;
        cmd.load_rd = 1'b0;
        cmd.step    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
            end
            S_READ:
            begin
                cmd.load_rd = 1'b1;
            end
            S_DRESP:
            begin
                out_valid = 1'b1;
                cmd.step  = out_ready && !sts.ptr_zero;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/bsiu_dp.sv */
// Datapath of the bounded stack: count, display pointer, result register
// and the entry RAM. Depends on bsiu_pkg and bsiu_ram.
module bsiu_dp
    import bsiu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    output out_item_t out_item,
    input  ctrl_cmd_t cmd,
    output dp_sts_t   sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [AW-1:0] ptr_reg;
    logic [AW-1:0] ptr_next;
    out_item_t     res_reg;
    out_item_t     res_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;

    logic          is_full;
    logic          is_empty;
    logic [XW-1:0] count_x;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] change_idx;
    logic [CW-1:0] count_m1;

    assign is_full    = (count_reg == CW'(DEPTH));
    assign is_empty   = (count_reg == '0);
    assign count_x    = XW'(count_reg);
    assign pos_x      = XW'(in_item.position);
    assign change_idx = count_x - pos_x;
    assign count_m1   = count_reg - CW'(1);

    assign sts.disp_start = (in_item.action == ACT_DISPLAY) && !is_empty;
    assign sts.ptr_zero   = (ptr_reg == '0);

    assign rd_addr = cmd.accept ? count_m1[AW-1:0] : (ptr_reg - AW'(1));

    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        if (cmd.accept)
        begin
            res_next.status = STS_OK;
            res_next.data   = '0;
            res_next.last   = 1'b1;
            unique case (in_item.action)
                ACT_PUSH:
                begin
                    if (is_full)
                    begin
                        res_next.status = STS_OVERFLOW;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                ACT_POP:
                begin
                    if (is_empty)
                    begin
                        res_next.status = STS_UNDERFLOW;
                    end
                    else
                    begin
                        count_next = count_m1;
                    end
                end
                ACT_CHANGE:
                begin
                    wr_addr = change_idx[AW-1:0];
                    if ((pos_x == '0) || (pos_x > count_x))
                    begin
                        res_next.status = STS_BAD_INDEX;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
                ACT_DISPLAY:
                begin
                    if (is_empty)
                    begin
                        res_next.status = STS_EMPTY;
                    end
                    else
                    begin
                        ptr_next = count_m1[AW-1:0];
                    end
                end
                default:
                begin
                    res_next.status = STS_OK;
                end
            endcase
        end
        else if (cmd.load_rd)
        begin
            res_next.status = STS_OK;
            res_next.data   = rd_data;
            res_next.last   = (ptr_reg == '0);
        end
        else if (cmd.step)
        begin
            ptr_next = ptr_reg - AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        res_reg <= res_next;
    end

    bsiu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_item.value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_item = res_reg;

endmodule

/* hdl/bounded_stack_with_indexed_update.sv */
// Top level of the bounded LIFO stack of signed words with indexed update.
// Depends on bsiu_pkg, bsiu_ctrl and bsiu_dp.
//
// Usage:
// The in channel (in_valid, in_ready, in_item) carries one action per transfer:
// push, pop, change at a 1-based position from the top, or display.
// The out channel (out_valid, out_ready, out_item) carries result transfers with
// a status, a data word and a last flag on the final result of each action.
// Push, pop and change give one result in the cycle after acceptance at the
// earliest; the next action is taken the cycle after that result transfers,
// so no new action is accepted while a result still awaits delivery.
// Display of N entries gives N results, each read from the entry RAM's
// registered port in S_READ and then offered in S_DRESP.
// An empty display gives one result with the empty status.
// in_ready is high only while no action is in progress or awaiting delivery.
// When the receiver stalls, the result is held in the output register and
// no further action or RAM read proceeds until it is taken.
// Reset empties the stack; the entry RAM is not cleared and needs no sweep.
module bounded_stack_with_indexed_update
    import bsiu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    bsiu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    bsiu_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .out_item (out_item),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

/* sim/stack_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the bounded stack with indexed update: watches both transfer
// channels, predicts each action's results and compares them field by field.
// Depends on bsiu_pkg.
module stack_result_checker
    import bsiu_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_item,
    output int        fail_count,
    output int        pending,
    output int        results_checked
);

    localparam int AW = $clog2(DEPTH);

    logic signed [WORD_W-1:0] model_words [DEPTH];
    int                       model_fill;
    out_item_t                pending_responses [$];

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic apply_stack_action(in_item_t req);
        out_item_t rsp;
        rsp        = '0;
        rsp.status = STS_OK;
        rsp.last   = 1'b1;
        case (req.action)
            ACT_PUSH:
            begin
                if (model_fill >= DEPTH)
                begin
                    rsp.status = STS_OVERFLOW;
                end
                else
                begin
                    model_words[AW'(model_fill)] = req.value;
                    model_fill++;
                end
                pending_responses.push_back(rsp);
            end
            ACT_POP:
            begin
                if (model_fill == 0)
                begin
                    rsp.status = STS_UNDERFLOW;
                end
                else
                begin
                    model_fill--;
                end
                pending_responses.push_back(rsp);
            end
            ACT_CHANGE:
            begin
                if (req.position == 0 || int'(req.position) > model_fill)
                begin
                    rsp.status = STS_BAD_INDEX;
                end
                else
                begin
                    model_words[AW'(model_fill - int'(req.position))] = req.value;
                end
                pending_responses.push_back(rsp);
            end
            ACT_DISPLAY:
            begin
                if (model_fill == 0)
                begin
                    rsp.status = STS_EMPTY;
                    pending_responses.push_back(rsp);
                end
                else
                begin
                    for (int i = model_fill; i > 0; i--)
                    begin
                        rsp.data = model_words[AW'(i - 1)];
                        rsp.last = (i == 1);
                        pending_responses.push_back(rsp);
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        out_item_t want;
        if (!rst_n)
        begin
            pending_responses.delete();
            model_fill      = 0;
            fail_count      = 0;
            results_checked = 0;
            pending        <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (pending_responses.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result: status %0d data %0d last %0b",
                        out_item.status, out_item.data, out_item.last));
                end
                else
                begin
                    want = pending_responses.pop_front();
                    if (out_item.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                            out_item.status, want.status));
                    if (out_item.data !== want.data)
                        report_mismatch($sformatf("data got %0d want %0d",
                            out_item.data, want.data));
                    if (out_item.last !== want.last)
                        report_mismatch($sformatf("last got %0b want %0b",
                            out_item.last, want.last));
                end
            end
            if (in_valid && in_ready)
            begin
                apply_stack_action(in_item);
            end
            pending <= pending_responses.size();
        end
    end

endmodule

/* sim/bounded_stack_with_indexed_update_test.sv */
`timescale 1ns / 100ps
// Testbench top for the bounded stack with indexed update: drives directed and
// random actions under three idling mixes and gives the verdict.
// Depends on bsiu_pkg, bounded_stack_with_indexed_update and stack_result_checker.
module bounded_stack_with_indexed_update_test;
    import bsiu_pkg::*;

    localparam int DEPTH           = DEPTH_DEF;
    localparam int ITEMS_PER_PHASE = 32;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 2 * DEPTH + 8;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    int send_idle_pct = 19;
    int recv_idle_pct = 48;
    int fill_estimate = 0;
    int stall_run     = 0;
    int sent_by_action [4];
    int fail_count;
    int pending;
    int results_checked;

    bounded_stack_with_indexed_update #(
        .DEPTH(DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    stack_result_checker #(
        .DEPTH(DEPTH)
    ) response_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_item        (out_item),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_run <= 0;
            end
            else if (stall_run >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles", stall_run);
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                stall_run <= stall_run + 1;
            end
        end
    end

    function automatic in_item_t make_item(action_t act, logic signed [WORD_W-1:0] val,
                                           logic [POS_W-1:0] pos);
        in_item_t req;
        req.action   = act;
        req.value    = val;
        req.position = pos;
        return req;
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_word();
        logic signed [WORD_W-1:0] word;
        case ($urandom_range(15))
            0:       word = 32'sh7FFFFFFF;
            1:       word = 32'sh80000000;
            2:       word = -32'sd1;
            3:       word = 32'sd0;
            default: word = $urandom;
        endcase
        return word;
    endfunction

    function automatic in_item_t random_action(bit growing);
        int               r;
        action_t          act;
        logic [POS_W-1:0] pos;
        r = $urandom_range(99);
        if (r < (growing ? 50 : 10))
            act = ACT_PUSH;
        else if (r < 60)
            act = ACT_POP;
        else if (r < 85)
            act = ACT_CHANGE;
        else
            act = ACT_DISPLAY;
        if (fill_estimate > 0 && $urandom_range(99) < 75)
            pos = POS_W'($urandom_range(fill_estimate, 1));
        else
            pos = POS_W'($urandom_range(31));
        return make_item(act, pick_word(), pos);
    endfunction

    task automatic send_action(in_item_t req);
        in_item_t noise;
        while ($urandom_range(99) < send_idle_pct)
        begin
            noise = make_item(action_t'($urandom_range(3)), $urandom,
                              POS_W'($urandom_range(31)));
            in_valid <= 1'b0;
            in_item  <= noise;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_by_action[req.action]++;
        if (req.action == ACT_PUSH && fill_estimate < DEPTH)
            fill_estimate++;
        else if (req.action == ACT_POP && fill_estimate > 0)
            fill_estimate--;
    endtask

    initial
    begin : stimulus
        bit growing;
        growing = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 19;
                    recv_idle_pct = 48;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_idle_pct = 19;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                send_action(make_item(ACT_DISPLAY, 32'sd0, 5'd0));
                send_action(make_item(ACT_POP, 32'sd0, 5'd0));
                send_action(make_item(ACT_CHANGE, 32'sd10, 5'd1));
                send_action(make_item(ACT_PUSH, 32'sh7FFFFFFF, 5'd31));
                send_action(make_item(ACT_PUSH, 32'sh80000000, 5'd0));
                send_action(make_item(ACT_PUSH, -32'sd1, 5'd0));
                send_action(make_item(ACT_PUSH, 32'sd0, 5'd0));
                send_action(make_item(ACT_CHANGE, 32'sd10, 5'd0));
                send_action(make_item(ACT_CHANGE, 32'sd10, 5'd5));
                send_action(make_item(ACT_CHANGE, 32'sd10, 5'd4));
                while (fill_estimate < DEPTH)
                    send_action(make_item(ACT_PUSH, $urandom, POS_W'($urandom_range(31))));
                send_action(make_item(ACT_PUSH, 32'sh5A5A5A5A, 5'd0));
                send_action(make_item(ACT_CHANGE, -32'sd1, 5'd31));
                send_action(make_item(ACT_DISPLAY, 32'sd0, 5'd0));
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(19) == 0)
                    growing = !growing;
                else if (fill_estimate == DEPTH && $urandom_range(3) == 0)
                    growing = 1'b0;
                else if (fill_estimate == 0 && $urandom_range(3) == 0)
                    growing = 1'b1;
                send_action(random_action(growing));
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d actions (%0d push, %0d pop, %0d change, %0d display) in three idle mixes.",
            sent_by_action[0] + sent_by_action[1] + sent_by_action[2] + sent_by_action[3],
            sent_by_action[0], sent_by_action[1], sent_by_action[2], sent_by_action[3]);
        $display("Compared %0d result transfers field by field, %0d mismatches found.",
            results_checked, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/bsiu_pkg.sv
hdl/bsiu_ram.sv
hdl/bsiu_ctrl.sv
hdl/bsiu_dp.sv
hdl/bounded_stack_with_indexed_update.sv
sim/stack_result_checker.sv
sim/bounded_stack_with_indexed_update_test.sv
